FILE: hw/rtl/plfr_pkg.sv
package plfr_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_PREAMBLE_BYTES  = 2'd0;
   localparam logic [1:0] CSR_PREAMBLE_LENGTH = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS   = 2'd2;

   // reset values of the configuration registers
   localparam logic [31:0] PREAMBLE_BYTES_RESET  = 32'd0;
   localparam logic [2:0]  PREAMBLE_LENGTH_RESET = 3'd4;
   localparam logic [31:0] TIMEOUT_TICKS_RESET   = 32'd2000;

   // event kinds on the input channel
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic [6:0] byte_position;
      logic       frame_end;
      logic [7:0] frame_total;
      logic       frame_dropped;
   } rsp_type;

endpackage

FILE: hw/rtl/preamble_length_frame_receiver_core.sv
// Preamble-hunting, length-prefixed frame receiver.
//
// Input channel (req_): one beat is either a received byte (kind = 0) or one
// timer tick (kind = 1). Every byte beat yields exactly one result beat on
// the rsp_ channel; a tick beat yields none and only advances the gap timer.
// Configuration (csr_) is a plain write port: preamble bytes, preamble
// length and tick timeout, written while the block is idle.
//
// A byte's result is registered, or held in the skid entry if the waiting result
// is stalled. Throughput is one beat per cycle while req_stall is low, set by the
// single compare-and-count stage between the state and result registers.
// A result register plus one skid entry separate the two channels, so the
// block keeps taking beats while one result waits. req_stall is the skid
// entry's valid: it rises when a byte comes in while the waiting result is
// stalled, and falls at the edge where the receiver takes a result.
//
// Synchronous reset clears the hunt state, the gap timer and both result
// slots, and loads the configuration defaults (length 4, timeout 2000).
module preamble_length_frame_receiver_core #(
   parameter int BUF_DEPTH    = 128,
   parameter int MAX_PREAMBLE = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plfr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plfr_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import plfr_pkg::*;

   localparam logic [7:0] DEPTH_LIMIT    = 8'(BUF_DEPTH);
   localparam logic [2:0] PREAMBLE_LIMIT = 3'(MAX_PREAMBLE);

   logic [31:0] preamble_bytes_ff;
   logic [2:0]  preamble_length_ff;
   logic [31:0] timeout_ticks_ff;

   logic [2:0]  matched_ff,  matched_in;
   logic [7:0]  expected_ff, expected_in;
   logic [7:0]  taken_ff,    taken_in;
   logic [31:0] gap_ff,      gap_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff,  rsp_data_in;
   logic        skid_valid_ff, skid_valid_in;
   rsp_type     skid_data_ff,  skid_data_in;

   logic        req_take;
   logic        byte_take;
   logic        out_free;
   logic        timeout_hit;
   logic [2:0]  match_start;
   logic [7:0]  taken_start;
   logic [2:0]  plen;
   logic [7:0]  want;
   logic [7:0]  taken_next;
   rsp_type     result;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign byte_take = req_take && (req_data.kind == KIND_BYTE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_bytes_ff  <= PREAMBLE_BYTES_RESET;
         preamble_length_ff <= PREAMBLE_LENGTH_RESET;
         timeout_ticks_ff   <= TIMEOUT_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PREAMBLE_BYTES:  preamble_bytes_ff  <= csr_wdata;
            CSR_PREAMBLE_LENGTH: preamble_length_ff <= csr_wdata[2:0];
            CSR_TIMEOUT_TICKS:   timeout_ticks_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective preamble length, clamped to 1..MAX_PREAMBLE
   always_comb begin
      plen = preamble_length_ff;
      if (plen == 3'd0) begin
         plen = 3'd1;
      end
      if (plen > PREAMBLE_LIMIT) begin
         plen = PREAMBLE_LIMIT;
      end
   end

   // timeout check ahead of the byte
   assign timeout_hit = gap_ff > timeout_ticks_ff;
   assign match_start = timeout_hit ? 3'd0 : matched_ff;
   assign taken_start = timeout_hit ? 8'd0 : taken_ff;
   assign taken_next  = taken_start + 8'd1;

   // preamble byte wanted at the current hunt position
   always_comb begin
      unique case (match_start[1:0])
         2'd0: want = preamble_bytes_ff[7:0];
         2'd1: want = preamble_bytes_ff[15:8];
         2'd2: want = preamble_bytes_ff[23:16];
         2'd3: want = preamble_bytes_ff[31:24];
         default: want = preamble_bytes_ff[7:0];
      endcase
   end

   // hunt / data phase for one received byte
   always_comb begin
      matched_in  = match_start;
      expected_in = expected_ff;
      taken_in    = taken_start;
      result      = '0;
      result.frame_dropped = timeout_hit && (taken_ff != 8'd0);
      if (match_start < plen) begin
         matched_in = (req_data.rx_byte == want) ? match_start + 3'd1 : 3'd0;
         taken_in   = 8'd0;
      end else if ((taken_start == 8'd0) &&
                   ((req_data.rx_byte == 8'd0) || (req_data.rx_byte > DEPTH_LIMIT))) begin
         // bad length byte: drop it and hunt again
         expected_in = req_data.rx_byte;
         matched_in  = 3'd0;
      end else begin
         if (taken_start == 8'd0) begin
            expected_in = req_data.rx_byte;
         end
         result.data_valid    = 1'b1;
         result.data_byte     = req_data.rx_byte;
         result.byte_position = taken_start[6:0];
         if (taken_next == expected_in) begin
            result.frame_end   = 1'b1;
            result.frame_total = expected_in;
            matched_in         = 3'd0;
            taken_in           = 8'd0;
         end else begin
            taken_in = taken_next;
         end
      end
   end

   // gap timer: ticks count up and saturate, bytes clear it
   always_comb begin
      gap_in = gap_ff;
      if (req_take) begin
         if (req_data.kind == KIND_TICK) begin
            if (gap_ff != '1) begin
               gap_in = gap_ff + 32'd1;
            end
         end else begin
            gap_in = '0;
         end
      end
   end

   // result register and skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (byte_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end
      end else if (byte_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff    <= '0;
         expected_ff   <= '0;
         taken_ff      <= '0;
         gap_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (byte_take) begin
            matched_ff  <= matched_in;
            expected_ff <= expected_in;
            taken_ff    <= taken_in;
         end
         gap_ff        <= gap_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while result register empty");

   a_end_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_end) |-> rsp_data_ff.data_valid)
      else $error("frame end on a beat that carries no frame byte");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.data_valid) |->
      (rsp_data_ff.data_byte == 8'd0 && rsp_data_ff.frame_total == 8'd0))
      else $error("non-frame beat carries byte or total");

   a_tick_clears_nothing: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.kind == KIND_TICK) |=>
      (matched_ff == $past(matched_ff) && taken_ff == $past(taken_ff)))
      else $error("tick changed hunt state");

endmodule
